@@ sv/fsg_pkg.sv @@
package fsg_pkg;

   // grid geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 63;

   // fixed field widths
   localparam int FUNC_W = 2;
   localparam int CRD_W  = 11;
   localparam int RADF_W = 6;
   localparam int DIM_W  = 9;
   localparam int PIX_W  = 32;

   // derived widths
   localparam int COL_AW  = $clog2(MAX_WIDTH);
   localparam int ROW_AW  = $clog2(MAX_HEIGHT);
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int SQ_W    = 2 * RAD_W + 1;
   localparam int MAXD_W  = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH + 1)
                                                     : $clog2(MAX_HEIGHT + 1);
   localparam int EXT_W   = (MAXD_W > DIM_W) ? MAXD_W : DIM_W;
   localparam int COORD_W = ((EXT_W > CRD_W) ? EXT_W : CRD_W) + 2;

   localparam int GRID_RESET = 256;

   // dimension register indexes
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // operation codes
   localparam logic [FUNC_W-1:0] OP_PAINT   = 2'd0;
   localparam logic [FUNC_W-1:0] OP_ERASE   = 2'd1;
   localparam logic [FUNC_W-1:0] OP_GRAVITY = 2'd2;
   localparam logic [FUNC_W-1:0] OP_READ    = 2'd3;

   // ABGR color of a filled cell
   localparam logic [PIX_W-1:0] FILLED_WORD = {8'd255, 8'd150, 8'd150, 8'd70};

   typedef logic [MAX_WIDTH-1:0] row_type;

endpackage

@@ sv/falling_sand_grid_with_disc_brush.sv @@
// Falling-sand occupancy grid with a disc brush.
//
// Input channel req_*: one transfer is one operation. req_tuser carries the
// opcode (paint disc, erase disc, gravity step, read cell), req_tdata the
// disc center or read position and the radius. Every operation gives exactly
// one transfer on rsp_*: color word and occupied flag of a read cell, else 0.
// The grid lives in a row-wide memory, one row per word, registered read.
// Steps from accept to rsp_tvalid:
//   read        a registered row read (none off the grid)
//   gravity     one row a cycle, bottom up (none with fewer than two rows)
//   paint/erase per disc row a half-width search (the last step issues the
//               row read) and a write-back for an on-grid row
// One operation at a time; req_tready is high whenever none is in progress,
// also while a result waits in the output register. A stalled receiver
// holds the result; once the next result is ready the block waits.
// Reset empties the grid at once through one valid bit per row, sets both
// dimensions to 256 and drops any pending result.
// csr_*: write-only dimension registers, index 0 width, 1 height.
module falling_sand_grid_with_disc_brush
   import fsg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [DIM_W-1:0] csr_wdata,
   // operations in
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // center_x[10:0], center_y[21:11], radius[27:22]
   input  logic [1:0]       req_tuser,   // func[1:0]
   // results out
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata    // pixel_value[31:0], occupied[32]
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RD_WAIT  = 3'd1;
   localparam logic [2:0] ST_GR_FIRST = 3'd2;
   localparam logic [2:0] ST_GR_ROW   = 3'd3;
   localparam logic [2:0] ST_GR_LAST  = 3'd4;
   localparam logic [2:0] ST_BR_ROW   = 3'd5;
   localparam logic [2:0] ST_BR_WAIT  = 3'd6;
   localparam logic [2:0] ST_RESULT   = 3'd7;

   // ---- registers ----
   logic [DIM_W-1:0]          grid_width_ff, grid_height_ff;
   logic [2:0]                state_ff, state_in;
   logic [FUNC_W-1:0]         func_ff, func_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_W-1:0]          r_ff, r_in;
   logic [RAD_W-1:0]          hw_ff, hw_in;
   logic signed [RAD_W:0]     dy_ff, dy_in;
   logic signed [COORD_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [ROW_AW-1:0]         row_ff, row_in;
   row_type                   below_ff, below_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_tvalid_ff;
   logic                      rsp_occ_ff;
   logic [PIX_W-1:0]          rsp_pix_ff;
   logic [MAX_HEIGHT-1:0]     row_valid_ff;
   logic                      valid_q_ff;
   row_type                   rd_data_ff;

   // ---- memory control ----
   row_type                   grid_mem [MAX_HEIGHT];
   logic                      mem_we, rd_en;
   logic [ROW_AW-1:0]         wr_addr, rd_addr;
   row_type                   wr_data;
   logic                      load_rsp;

   // ---- datapath ----
   logic [EXT_W-1:0]          eff_w, eff_h;
   logic signed [CRD_W-1:0]   in_x_raw, in_y_raw;
   logic signed [COORD_W-1:0] in_x, in_y;
   logic                      in_on_grid;
   logic [RADF_W-1:0]         in_rad;
   logic [RAD_W-1:0]          r_sat;
   row_type                   rdata, col_mask, brush_mask, move;
   logic [RAD_W-1:0]          dy_mag;
   logic [SQ_W-1:0]           dist_sq, r_sq;
   logic                      too_far;
   logic signed [COORD_W-1:0] y_row, lo_calc, hi_calc;
   logic                      y_on;
   logic                      last_row;

   assign eff_w = (EXT_W'(grid_width_ff) > EXT_W'(MAX_WIDTH))
                  ? EXT_W'(MAX_WIDTH) : EXT_W'(grid_width_ff);
   assign eff_h = (EXT_W'(grid_height_ff) > EXT_W'(MAX_HEIGHT))
                  ? EXT_W'(MAX_HEIGHT) : EXT_W'(grid_height_ff);

   // request decode
   assign in_x_raw   = signed'(req_tdata[10:0]);
   assign in_y_raw   = signed'(req_tdata[21:11]);
   assign in_rad     = req_tdata[27:22];
   assign in_x       = COORD_W'(in_x_raw);
   assign in_y       = COORD_W'(in_y_raw);
   assign in_on_grid = (in_x >= 0) && (in_y >= 0)
                       && ($unsigned(in_x) < COORD_W'(eff_w))
                       && ($unsigned(in_y) < COORD_W'(eff_h));
   assign r_sat = (RADF_W'(in_rad) > RADF_W'(MAX_RADIUS))
                  ? RAD_W'(MAX_RADIUS) : RAD_W'(in_rad);

   // rows never written read as empty
   assign rdata = valid_q_ff ? rd_data_ff : '0;

   // half-width search: shrink hw until hw^2 + dy^2 <= r^2
   assign dy_mag   = dy_ff[RAD_W] ? RAD_W'(-dy_ff) : RAD_W'(dy_ff);
   assign dist_sq  = SQ_W'(hw_ff) * SQ_W'(hw_ff) + SQ_W'(dy_mag) * SQ_W'(dy_mag);
   assign r_sq     = SQ_W'(r_ff) * SQ_W'(r_ff);
   assign too_far  = dist_sq > r_sq;
   assign last_row = (dy_ff == signed'({1'b0, r_ff}));

   assign y_row   = cy_ff + COORD_W'(dy_ff);
   assign lo_calc = cx_ff - signed'(COORD_W'(hw_ff));
   assign hi_calc = cx_ff + signed'(COORD_W'(hw_ff));
   assign y_on    = (y_row >= 0) && ($unsigned(y_row) < COORD_W'(eff_h));

   always_comb begin
      logic signed [COORD_W-1:0] col_s;
      col_s = '0;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         col_s         = signed'(COORD_W'(c));
         col_mask[c]   = EXT_W'(c) < eff_w;
         brush_mask[c] = col_mask[c] && (col_s >= lo_ff) && (col_s <= hi_ff);
      end
   end

   assign move = rdata & ~below_ff & col_mask;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      r_in     = r_ff;
      hw_in    = hw_ff;
      dy_in    = dy_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      row_in   = row_ff;
      below_in = below_ff;
      hit_in   = hit_ff;
      mem_we   = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               cx_in   = in_x;
               cy_in   = in_y;
               r_in    = r_sat;
               hw_in   = r_sat;
               dy_in   = -signed'({1'b0, r_sat});
               hit_in  = 1'b0;
               case (req_tuser)
                  OP_READ: begin
                     if (in_on_grid) begin
                        rd_en    = 1'b1;
                        rd_addr  = in_y[ROW_AW-1:0];
                        state_in = ST_RD_WAIT;
                     end else begin
                        state_in = ST_RESULT;
                     end
                  end
                  OP_GRAVITY: begin
                     if (eff_h < EXT_W'(2)) begin
                        state_in = ST_RESULT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = ROW_AW'(eff_h - EXT_W'(1));
                        row_in   = ROW_AW'(eff_h - EXT_W'(1));
                        state_in = ST_GR_FIRST;
                     end
                  end
                  default: begin
                     state_in = ST_BR_ROW;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            hit_in   = rdata[cx_ff[COL_AW-1:0]];
            state_in = ST_RESULT;
         end
         ST_GR_FIRST: begin
            // bottom row in hand; fetch the one above
            below_in = rdata;
            rd_en    = 1'b1;
            rd_addr  = row_ff - 1'b1;
            row_in   = row_ff - 1'b1;
            state_in = ST_GR_ROW;
         end
         ST_GR_ROW: begin
            mem_we   = 1'b1;
            wr_addr  = row_ff + 1'b1;
            wr_data  = below_ff | move;
            below_in = rdata & ~move;
            if (row_ff == '0) begin
               state_in = ST_GR_LAST;
            end else begin
               rd_en   = 1'b1;
               rd_addr = row_ff - 1'b1;
               row_in  = row_ff - 1'b1;
            end
         end
         ST_GR_LAST: begin
            mem_we   = 1'b1;
            wr_addr  = row_ff;
            wr_data  = below_ff;
            state_in = ST_RESULT;
         end
         ST_BR_ROW: begin
            if (too_far) begin
               hw_in = hw_ff - 1'b1;
            end else if (y_on) begin
               lo_in    = lo_calc;
               hi_in    = hi_calc;
               row_in   = y_row[ROW_AW-1:0];
               rd_en    = 1'b1;
               rd_addr  = y_row[ROW_AW-1:0];
               state_in = ST_BR_WAIT;
            end else if (last_row) begin
               state_in = ST_RESULT;
            end else begin
               dy_in = dy_ff + 1'b1;
               hw_in = r_ff;
            end
         end
         ST_BR_WAIT: begin
            mem_we  = 1'b1;
            wr_addr = row_ff;
            wr_data = (func_ff == OP_PAINT) ? (rdata | brush_mask) : (rdata & ~brush_mask);
            if (last_row) begin
               state_in = ST_RESULT;
            end else begin
               dy_in    = dy_ff + 1'b1;
               hw_in    = r_ff;
               state_in = ST_BR_ROW;
            end
         end
         ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= DIM_W'(GRID_RESET);
         grid_height_ff <= DIM_W'(GRID_RESET);
         rsp_tvalid_ff  <= 1'b0;
         row_valid_ff   <= '0;
         valid_q_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               REG_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
               REG_GRID_HEIGHT: grid_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (mem_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            valid_q_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      r_ff     <= r_in;
      hw_ff    <= hw_in;
      dy_ff    <= dy_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      row_ff   <= row_in;
      below_ff <= below_in;
      hit_ff   <= hit_in;
      if (load_rsp) begin
         rsp_occ_ff <= hit_ff;
         rsp_pix_ff <= hit_ff ? FILLED_WORD : '0;
      end
   end

   // ---- grid memory ----
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_occ_ff, rsp_pix_ff};

   // ---- assertions ----
   // a row is never read and written in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en) |-> (wr_addr != rd_addr))
      else $error("grid row read and written in the same cycle");

   // the half-width search always stops at or above zero
   a_hw_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BR_ROW && hw_ff == '0) |-> !too_far)
      else $error("disc half-width search underflow");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten");

   // a hit only comes from a read operation
   a_hit_only_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && hit_ff) |-> (func_ff == OP_READ))
      else $error("occupied flag set for a non-read operation");

endmodule

@@ sim/falling_sand_grid_with_disc_brush_tb.sv @@
module falling_sand_grid_with_disc_brush_tb;
   import fsg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // cycles without any transfer before the run is declared hung; the slowest
   // operation is a radius-63 disc
   localparam int HANG_LIMIT = 100000;
   // quiet cycles after the last result, to catch stray transfers
   localparam int DRAIN_CYCLES = 20;

   // random phases: dimensions written before each, and item count
   localparam int PHASES = 8;
   localparam int PHASE_W [PHASES] = '{16, 1, 256, 1,   0,  511, 7, 40};
   localparam int PHASE_H [PHASES] = '{12, 1, 1,   256, 37, 300, 5, 30};
   localparam int PHASE_N [PHASES] = '{16, 5, 6,   6,   5,  10,  14, 14};

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [CRD_W-1:0]  cx;
      logic signed [CRD_W-1:0]  cy;
      logic [RADF_W-1:0]        radius;
   } sand_op_type;

   typedef struct packed {
      logic [PIX_W-1:0] color;
      logic             filled;
   } cell_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic              csr_addr = 1'b0;
   logic [DIM_W-1:0]  csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;   // center_x[10:0], center_y[21:11], radius[27:22]
   logic [1:0]        req_tuser = '0;   // func[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;        // pixel_value[31:0], occupied[32]

   // shadow of the block: occupancy grid and dimension registers
   bit                sand [MAX_HEIGHT][MAX_WIDTH];
   int unsigned       grid_w = GRID_RESET;
   int unsigned       grid_h = GRID_RESET;

   sand_op_type       pending_ops [$];
   cell_report_type   expected_cells [$];
   sand_op_type       op_in_flight;
   int                fail_count = 0;
   int                req_gap = 0;
   int                rsp_gap = 0;
   int                hang_count = 0;
   bit                calm = 1'b0;      // no idling on either side when set

   falling_sand_grid_with_disc_brush dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // grid shadow
   // ---------------------------------------------------------------------

   // oversized dimensions saturate; zero leaves no cell at all
   function automatic int cols_in_use();
      return (grid_w > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w);
   endfunction

   function automatic int rows_in_use();
      return (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h);
   endfunction

   function automatic bit on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < cols_in_use() && y < rows_in_use();
   endfunction

   // apply one operation to the shadow grid and return its result
   function automatic cell_report_type apply_sand_op(sand_op_type op);
      cell_report_type res;
      int x;
      int y;
      int r;
      int w;
      int h;
      x = op.cx;          // sign extends
      y = op.cy;
      r = op.radius;
      w = cols_in_use();
      h = rows_in_use();
      res = '0;
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      case (op.func)
         OP_PAINT, OP_ERASE: begin
            for (int dx = -r; dx <= r; dx++)
               for (int dy = -r; dy <= r; dy++)
                  if (dx * dx + dy * dy <= r * r && on_grid(x + dx, y + dy))
                     sand[y + dy][x + dx] = (op.func == OP_PAINT);
         end
         OP_GRAVITY: begin
            // bottom row up, left to right; a grain moves at most one row
            for (int row = h - 2; row >= 0; row--)
               for (int col = 0; col < w; col++)
                  if (sand[row][col] && !sand[row + 1][col]) begin
                     sand[row + 1][col] = 1'b1;
                     sand[row][col] = 1'b0;
                  end
         end
         default: begin
            if (on_grid(x, y) && sand[y][x]) begin
               res.color = FILLED_WORD;
               res.filled = 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic void queue_op(logic [FUNC_W-1:0] func, int x, int y, int r);
      sand_op_type op;
      op.func = func;
      op.cx = x[CRD_W-1:0];
      op.cy = y[CRD_W-1:0];
      op.radius = r[RADF_W-1:0];
      pending_ops.push_back(op);
   endfunction

   // mostly small brushes near the used corner of the grid, some full-range noise
   function automatic sand_op_type random_sand_op();
      sand_op_type op;
      int pick;
      int span_x;
      int span_y;
      int v;
      span_x = (cols_in_use() > 48) ? 48 : cols_in_use();
      span_y = (rows_in_use() > 48) ? 48 : rows_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 35)      op.func = OP_PAINT;
      else if (pick < 47) op.func = OP_ERASE;
      else if (pick < 65) op.func = OP_GRAVITY;
      else                op.func = OP_READ;
      if ($urandom_range(0, 9) < 8) begin
         v = int'($urandom_range(0, span_x + 7)) - 4;
         op.cx = v[CRD_W-1:0];
         v = int'($urandom_range(0, span_y + 7)) - 4;
         op.cy = v[CRD_W-1:0];
      end else begin
         op.cx = CRD_W'($urandom);
         op.cy = CRD_W'($urandom);
      end
      if ($urandom_range(0, 4) != 0) op.radius = RADF_W'($urandom_range(0, 6));
      else                           op.radius = RADF_W'($urandom_range(0, 63));
      return op;
   endfunction

   // block idle: nothing queued, nothing offered, no result outstanding
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_tvalid || expected_cells.size() != 0);
   endtask

   task automatic write_dims(int unsigned w, int unsigned h);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_GRID_WIDTH;
      csr_wdata <= w[DIM_W-1:0];
      @(posedge clock);
      csr_addr  <= REG_GRID_HEIGHT;
      csr_wdata <= h[DIM_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      grid_w = w & 32'h1FF;
      grid_h = h & 32'h1FF;
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // driver: offers queued operations, predicts at each accepted transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_cells.push_back(apply_sand_op(op_in_flight));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
               // idle burst that starts here
               req_gap = $urandom_range(0, 8);
               req_tvalid <= 1'b0;
            end else begin
               op_in_flight = pending_ops.pop_front();
               req_tdata  <= {4'b0, op_in_flight.radius, op_in_flight.cy, op_in_flight.cx};
               req_tuser  <= op_in_flight.func;
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks each result transfer against the oldest prediction,
   // stalls rsp_tready in bursts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cell_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cells.size() == 0) begin
               report_mismatch("unexpected result, pixel_value", rsp_tdata[31:0], '0);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tdata[31:0] !== want.color)
                  report_mismatch("pixel_value", rsp_tdata[31:0], want.color);
               if (rsp_tdata[32] !== want.filled)
                  report_mismatch("occupied", {31'b0, rsp_tdata[32]}, {31'b0, want.filled});
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: any transfer restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         hang_count = 0;
      end else begin
         hang_count++;
         if (hang_count >= HANG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     HANG_LIMIT, expected_cells.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, full 256 x 256 grid after reset
      queue_op(OP_READ,    0,    0,    0);    // empty after reset
      queue_op(OP_PAINT,   0,    0,    0);    // single grain, top-left corner
      queue_op(OP_READ,    0,    0,    0);
      queue_op(OP_READ,   -1,    0,    0);    // off grid, left
      queue_op(OP_READ,    0,   -1,    0);    // off grid, top
      queue_op(OP_PAINT,   255,  255,  0);    // bottom-right corner
      queue_op(OP_READ,    255,  255,  0);
      queue_op(OP_READ,    256,  255,  0);    // one past the last column
      queue_op(OP_READ,    255,  256,  0);    // one past the last row
      queue_op(OP_PAINT,  -1024, -1024, 63);  // disc entirely off grid
      queue_op(OP_PAINT,   1023, 1023, 63);
      queue_op(OP_PAINT,   128,  128,  63);   // full disc, largest radius
      queue_op(OP_READ,    65,   128,  0);    // leftmost point of the rim
      queue_op(OP_READ,    64,   128,  0);    // just outside
      queue_op(OP_READ,    173,  173,  0);    // diagonal just outside
      queue_op(OP_READ,    172,  172,  0);    // diagonal just inside
      queue_op(OP_ERASE,   128,  128,  62);   // leaves the outer ring
      queue_op(OP_READ,    65,   128,  0);
      queue_op(OP_READ,    128,  128,  0);
      queue_op(OP_ERASE,  -3,   -3,    5);    // off-center disc clips the corner grain
      queue_op(OP_GRAVITY, 0,    0,    0);
      queue_op(OP_READ,    0,    0,    0);
      queue_op(OP_READ,    255,  255,  0);    // bottom row cannot fall
      queue_op(OP_READ,    65,   129,  0);    // rim grain fell one row
      queue_op(OP_READ,    65,   128,  0);
      wait_drained();

      // random phases across grid sizes: tiny, single row/column, zero width,
      // oversized (saturating), and ordinary sizes; last phase runs without idling
      for (int p = 0; p < PHASES; p++) begin
         write_dims(PHASE_W[p], PHASE_H[p]);
         @(negedge clock);
         if (p == PHASES - 1) calm = 1'b1;
         for (int k = 0; k < PHASE_N[p]; k++)
            pending_ops.push_back(random_sand_op());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/fsg_pkg.sv
sv/falling_sand_grid_with_disc_brush.sv
sim/falling_sand_grid_with_disc_brush_tb.sv
